[design/bpc_pkg.sv]
// Shared types and constants for the button press classifier.
package bpc_pkg;

    localparam int BPC_COUNT_WIDTH = 16;
    localparam int REG_W           = 16;
    localparam int REG_IDX_W       = 3;

    localparam logic [REG_W-1:0] PRESCALE_LIMIT_RST = 16'd50;
    localparam logic [REG_W-1:0] LONG_LIMIT_RST     = 16'd2000;
    localparam logic [REG_W-1:0] LONG_FIRE_RST      = 16'd1999;
    localparam logic [REG_W-1:0] SHORT_MIN_RST      = 16'd100;
    localparam logic [REG_W-1:0] SHORT_MAX_RST      = 16'd1900;
    localparam logic [REG_W-1:0] HOLD_LIMIT_RST     = 16'd5000;
    localparam logic [REG_W-1:0] HOLD_MIN_RST       = 16'd1000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PRESCALE_LIMIT = 3'd0,
        REG_LONG_LIMIT     = 3'd1,
        REG_LONG_FIRE      = 3'd2,
        REG_SHORT_MIN      = 3'd3,
        REG_SHORT_MAX      = 3'd4,
        REG_HOLD_LIMIT     = 3'd5,
        REG_HOLD_MIN       = 3'd6
    } bpc_reg_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_ONE_LONG  = 3'd1,
        EV_ONE_SHORT = 3'd2,
        EV_TWO       = 3'd3,
        EV_THREE     = 3'd4
    } bpc_event_t;

    typedef struct packed {
        logic [REG_W-1:0] prescale_limit;
        logic [REG_W-1:0] long_limit;
        logic [REG_W-1:0] long_fire;
        logic [REG_W-1:0] short_min;
        logic [REG_W-1:0] short_max;
        logic [REG_W-1:0] hold_limit;
        logic [REG_W-1:0] hold_min;
    } bpc_cfg_t;

    // Button one result toward the priority logic.
    typedef struct packed {
        logic long_press;
        logic short_press;
    } bpc_one_ev_t;

endpackage

[design/button_press_classifier.sv]
// Top level of the button press classifier: priority logic and output register.
//
// Each input transaction is one poll tick carrying three active-low button
// levels; each tick yields exactly one output transaction with an event code
// (0 none, 1 button one long, 2 button one short, 3 button two, 4 button three).
// Results are registered and appear in the cycle after the tick is accepted. A new tick
// is taken every cycle unless a result waits unaccepted: the counters and compares
// settle between the accepted tick and the output register, and the input side stays
// ready while the pending result is being taken. Buttons are evaluated in order and
// the first event ends the tick, so later buttons keep their counters on that tick.
// Configuration writes take effect at the next clock edge and are meant for an idle block.
module button_press_classifier
    import bpc_pkg::*;
#(
    parameter int COUNT_WIDTH = BPC_COUNT_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] button_one_level, [1] button_two_level,
                                            // [2] button_three_level, [7:3] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [2:0] press_event, [7:3] zero
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    bpc_cfg_t    cfg;
    bpc_one_ev_t one_ev;
    logic        accept;
    logic        two_fire;
    logic        three_fire;
    logic        two_update;
    logic        three_update;
    bpc_event_t  ev_comb;
    bpc_event_t  event_reg;
    bpc_event_t  event_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // a reported event blocks the buttons that follow it
    assign two_update   = accept && !one_ev.long_press && !one_ev.short_press;
    assign three_update = two_update && !two_fire;

    bpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpc_one #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_one (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (accept),
        .level  (s_tdata[0]),
        .cfg    (cfg),
        .ev     (one_ev)
    );

    bpc_hold #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_two (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (two_update),
        .level      (s_tdata[1]),
        .hold_limit (cfg.hold_limit),
        .hold_min   (cfg.hold_min),
        .fire       (two_fire)
    );

    bpc_hold #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_three (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (three_update),
        .level      (s_tdata[2]),
        .hold_limit (cfg.hold_limit),
        .hold_min   (cfg.hold_min),
        .fire       (three_fire)
    );

    always_comb
    begin
        if (one_ev.long_press)
        begin
            ev_comb = EV_ONE_LONG;
        end
        else if (one_ev.short_press)
        begin
            ev_comb = EV_ONE_SHORT;
        end
        else if (two_fire)
        begin
            ev_comb = EV_TWO;
        end
        else if (three_fire)
        begin
            ev_comb = EV_THREE;
        end
        else
        begin
            ev_comb = EV_NONE;
        end
    end

    always_comb
    begin
        event_next    = event_reg;
        m_tvalid_next = m_tvalid_reg;
        if (accept)
        begin
            event_next    = ev_comb;
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        event_reg <= event_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, event_reg};

endmodule

[design/bpc_cfg.sv]
// Configuration register file for the button press classifier.
module bpc_cfg
    import bpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output bpc_cfg_t             cfg
);

    bpc_cfg_t cfg_reg;
    bpc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PRESCALE_LIMIT: cfg_next.prescale_limit = cfg_data;
                REG_LONG_LIMIT:     cfg_next.long_limit     = cfg_data;
                REG_LONG_FIRE:      cfg_next.long_fire      = cfg_data;
                REG_SHORT_MIN:      cfg_next.short_min      = cfg_data;
                REG_SHORT_MAX:      cfg_next.short_max      = cfg_data;
                REG_HOLD_LIMIT:     cfg_next.hold_limit     = cfg_data;
                REG_HOLD_MIN:       cfg_next.hold_min       = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescale_limit <= PRESCALE_LIMIT_RST;
            cfg_reg.long_limit     <= LONG_LIMIT_RST;
            cfg_reg.long_fire      <= LONG_FIRE_RST;
            cfg_reg.short_min      <= SHORT_MIN_RST;
            cfg_reg.short_max      <= SHORT_MAX_RST;
            cfg_reg.hold_limit     <= HOLD_LIMIT_RST;
            cfg_reg.hold_min       <= HOLD_MIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/bpc_one.sv]
// Button one: prescaler, hold counter, long and short press detection.
module bpc_one
    import bpc_pkg::*;
#(
    parameter int COUNT_WIDTH = BPC_COUNT_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        update,
    input  logic        level,
    input  bpc_cfg_t    cfg,
    output bpc_one_ev_t ev
);

    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] pre_reg;
    logic [COUNT_WIDTH-1:0] pre_next;
    logic [COUNT_WIDTH-1:0] hold_reg;
    logic [COUNT_WIDTH-1:0] hold_next;
    logic [COUNT_WIDTH-1:0] hold_inc;
    logic                   pre_adv;
    logic                   hold_adv;

    always_comb
    begin
        hold_inc = hold_reg + COUNT_WIDTH'(1);
        pre_adv  = (CMP_W'(pre_reg) < CMP_W'(cfg.prescale_limit)) && (pre_reg != CNT_MAX);
        hold_adv = (CMP_W'(hold_reg) < CMP_W'(cfg.long_limit)) && (hold_reg != CNT_MAX);
        pre_next  = pre_reg;
        hold_next = hold_reg;
        ev        = '0;
        if (!level)
        begin
            if (pre_adv)
            begin
                pre_next = pre_reg + COUNT_WIDTH'(1);
            end
            else
            begin
                pre_next = '0;
                if (hold_adv)
                begin
                    hold_next     = hold_inc;
                    ev.long_press = (CMP_W'(hold_inc) == CMP_W'(cfg.long_fire));
                end
            end
        end
        else
        begin
            // prescaler keeps its phase across a release
            hold_next      = '0;
            ev.short_press = (CMP_W'(hold_reg) > CMP_W'(cfg.short_min)) &&
                             (CMP_W'(hold_reg) < CMP_W'(cfg.short_max));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg  <= '0;
            hold_reg <= '0;
        end
        else if (update)
        begin
            pre_reg  <= pre_next;
            hold_reg <= hold_next;
        end
    end

endmodule

[design/bpc_hold.sv]
// Hold counter and release detection for buttons two and three.
module bpc_hold
    import bpc_pkg::*;
#(
    parameter int COUNT_WIDTH = BPC_COUNT_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             update,
    input  logic             level,
    input  logic [REG_W-1:0] hold_limit,
    input  logic [REG_W-1:0] hold_min,
    output logic             fire
);

    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        fire     = 1'b0;
        if (!level)
        begin
            if ((CMP_W'(cnt_reg) < CMP_W'(hold_limit)) && (cnt_reg != CNT_MAX))
            begin
                cnt_next = cnt_reg + COUNT_WIDTH'(1);
            end
        end
        else
        begin
            cnt_next = '0;
            fire     = (CMP_W'(cnt_reg) > CMP_W'(hold_min));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (update)
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule
